[hw/rtl/circular_deque_core_defines.svh]
// assertion macros for the circular deque core
`ifndef CIRCULAR_DEQUE_CORE_DEFINES_SVH
`define CIRCULAR_DEQUE_CORE_DEFINES_SVH

`ifndef SYNTH

// property checked on every rising edge, masked while reset is low
`define CDQ_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property checked on every rising edge, reset included
`define CDQ_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define CDQ_ASSERT_RST(label, prop, msg)

`define CDQ_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

[hw/rtl/cdq_pkg.sv]
// shared types, constants and operation codes of the circular deque
`timescale 1ns / 1ps
`default_nettype none

package cdq_pkg;

    // built storage depth and derived widths
    localparam int DEPTH     = 64;
    localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CAP_W     = $clog2(DEPTH + 1);
    localparam int CFG_W     = 7;
    localparam int MODE_W    = 3;
    localparam int DATA_W    = 32;
    localparam int CAP_RESET = (64 > DEPTH) ? DEPTH : 64;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_REAR  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP_REAR   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_PEEK_FRONT = 3'd4;
    localparam logic [MODE_W-1:0] MODE_PEEK_REAR  = 3'd5;

    // answer for pushes, misses and unused codes
    localparam logic signed [DATA_W-1:0] DATA_NONE = '1;

    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic signed [DATA_W-1:0] value;
    } req_item_t;

    typedef struct packed {
        logic                     ok;
        logic signed [DATA_W-1:0] data;
        logic                     now_empty;
        logic                     now_full;
    } rsp_item_t;

    // decision of the index control for the item on offer
    typedef struct packed {
        logic             ok;
        logic             rd_en;
        logic             wr_en;
        logic [IDX_W-1:0] addr;
        logic             now_empty;
        logic             now_full;
    } step_t;

endpackage

`default_nettype wire

[hw/rtl/circular_deque_core.sv]
// top level of the circular deque: handshakes, sequencing and result register
//
//  channel | direction | payload      | handshake
//  req     | in        | req_item_t   | req_valid / req_ready
//  rsp     | out       | rsp_item_t   | rsp_valid / rsp_ready
//  cfg     | in        | capacity (7) | cfg_valid / cfg_ready
//
// push and miss items: the result is registered in the cycle after acceptance; pop and
// peek: the storage ram registers the read word, then the result register takes it.
// one item is in work at a time; a new item is taken in the cycle its result
// leaves or later, so no item is taken before the last one is through.
// reset empties the deque and sets capacity to the built depth; storage is not
// cleared. a capacity write also empties the deque.
`timescale 1ns / 1ps
`default_nettype none
`include "circular_deque_core_defines.svh"

module circular_deque_core (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      req_valid,
    output logic                           req_ready,
    input  wire cdq_pkg::req_item_t        req,
    output logic                           rsp_valid,
    input  wire logic                      rsp_ready,
    output cdq_pkg::rsp_item_t             rsp,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [cdq_pkg::CFG_W-1:0] cfg_data
);

    import cdq_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } state_t;

    state_t            state_reg;
    logic              rsp_valid_reg;
    rsp_item_t         rsp_reg;
    logic              pend_ok_reg;
    logic              pend_empty_reg;
    logic              pend_full_reg;
    step_t             step;
    logic              fire;
    logic              cfg_wr;
    logic [DATA_W-1:0] ram_rdata;

    assign req_ready = (state_reg == ST_IDLE) && (!rsp_valid_reg || rsp_ready);
    assign fire      = req_valid && req_ready;
    assign cfg_ready = (state_reg == ST_IDLE);
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // index control
    cdq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .mode     (req.mode),
        .cfg_wr   (cfg_wr),
        .cfg_data (cfg_data),
        .step     (step)
    );

    // word storage
    cdq_ram #(
        .DATA_W (DATA_W),
        .WORDS  (DEPTH),
        .ADDR_W (IDX_W)
    ) u_ram (
        .clk   (clk),
        .wr_en (fire && step.wr_en),
        .rd_en (fire && step.rd_en),
        .addr  (step.addr),
        .wdata (req.value),
        .rdata (ram_rdata)
    );

    // sequencer and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (fire && step.rd_en)
                    begin
                        state_reg     <= ST_READ;
                        rsp_valid_reg <= 1'b0;
                    end
                    else if (fire)
                    begin
                        rsp_valid_reg <= 1'b1;
                    end
                    else if (rsp_ready)
                    begin
                        rsp_valid_reg <= 1'b0;
                    end
                end
                ST_READ:
                begin
                    state_reg     <= ST_IDLE;
                    rsp_valid_reg <= 1'b1;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_READ)
        begin
            rsp_reg.ok        <= pend_ok_reg;
            rsp_reg.data      <= ram_rdata;
            rsp_reg.now_empty <= pend_empty_reg;
            rsp_reg.now_full  <= pend_full_reg;
        end
        else if (fire)
        begin
            pend_ok_reg    <= step.ok;
            pend_empty_reg <= step.now_empty;
            pend_full_reg  <= step.now_full;
            if (!step.rd_en)
            begin
                rsp_reg.ok        <= step.ok;
                rsp_reg.data      <= DATA_NONE;
                rsp_reg.now_empty <= step.now_empty;
                rsp_reg.now_full  <= step.now_full;
            end
        end
    end

    // checks
    `CDQ_ASSERT_RST(a_read_gives_result, (state_reg == ST_READ) |=> rsp_valid, "read lost its result")
    `CDQ_ASSERT_RST(a_miss_data, (rsp_valid && !rsp.ok) |-> (rsp.data == DATA_NONE), "failed item with data")
    `CDQ_ASSERT_RST(a_flags_exclusive, rsp_valid |-> !(rsp.now_empty && rsp.now_full), "empty and full together")
    `CDQ_ASSERT_ALWAYS(a_ram_one_access, !(step.rd_en && step.wr_en), "read and write decided together")

endmodule

`default_nettype wire

[hw/rtl/cdq_ram.sv]
// single-port synchronous ram with a registered read
`timescale 1ns / 1ps
`default_nettype none

module cdq_ram #(
    parameter int DATA_W = 32,
    parameter int WORDS  = 64,
    parameter int ADDR_W = 6
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic [DATA_W-1:0] wdata,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [WORDS];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wdata;
        end
        if (rd_en)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

`default_nettype wire

[hw/rtl/cdq_ctrl.sv]
// head, tail, empty and capacity registers with the per-item decision
`timescale 1ns / 1ps
`default_nettype none

module cdq_ctrl (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          fire,
    input  wire logic [cdq_pkg::MODE_W-1:0]    mode,
    input  wire logic                          cfg_wr,
    input  wire logic [cdq_pkg::CFG_W-1:0]     cfg_data,
    output cdq_pkg::step_t                     step
);

    import cdq_pkg::*;

    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic             empty_reg, empty_next;
    logic [CAP_W-1:0] cap_reg, cap_next;
    logic             full_now;

    // step upward modulo capacity
    function automatic logic [IDX_W-1:0] wrap_up(input logic [IDX_W-1:0] i,
                                                 input logic [CAP_W-1:0] cap);
        logic [CAP_W-1:0] nx;
        nx = CAP_W'(i) + CAP_W'(1);
        return (nx >= cap) ? '0 : nx[IDX_W-1:0];
    endfunction

    // step downward modulo capacity
    function automatic logic [IDX_W-1:0] wrap_down(input logic [IDX_W-1:0] i,
                                                   input logic [CAP_W-1:0] cap);
        logic [CAP_W-1:0] top;
        top = cap - CAP_W'(1);
        return (i == '0) ? top[IDX_W-1:0] : i - IDX_W'(1);
    endfunction

    assign full_now = !empty_reg && (wrap_up(tail_reg, cap_reg) == head_reg);

    // clamp a capacity write into one to the built depth
    always_comb
    begin
        if (cfg_data == '0)
        begin
            cap_next = CAP_W'(1);
        end
        else if (32'(cfg_data) > 32'(DEPTH))
        begin
            cap_next = CAP_W'(DEPTH);
        end
        else
        begin
            cap_next = CAP_W'(cfg_data);
        end
    end

    // decision for the item on offer
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        empty_next = empty_reg;
        step.ok    = 1'b0;
        step.rd_en = 1'b0;
        step.wr_en = 1'b0;
        step.addr  = head_reg;
        unique case (mode)
            MODE_PUSH_FRONT, MODE_PUSH_REAR:
            begin
                if (!full_now)
                begin
                    step.ok    = 1'b1;
                    step.wr_en = 1'b1;
                    if (empty_reg)
                    begin
                        head_next  = '0;
                        tail_next  = '0;
                        empty_next = 1'b0;
                        step.addr  = '0;
                    end
                    else if (mode == MODE_PUSH_FRONT)
                    begin
                        head_next = wrap_down(head_reg, cap_reg);
                        step.addr = head_next;
                    end
                    else
                    begin
                        tail_next = wrap_up(tail_reg, cap_reg);
                        step.addr = tail_next;
                    end
                end
            end
            MODE_POP_FRONT, MODE_POP_REAR:
            begin
                if (!empty_reg)
                begin
                    step.ok    = 1'b1;
                    step.rd_en = 1'b1;
                    step.addr  = (mode == MODE_POP_FRONT) ? head_reg : tail_reg;
                    if (head_reg == tail_reg)
                    begin
                        head_next  = '0;
                        tail_next  = '0;
                        empty_next = 1'b1;
                    end
                    else if (mode == MODE_POP_FRONT)
                    begin
                        head_next = wrap_up(head_reg, cap_reg);
                    end
                    else
                    begin
                        tail_next = wrap_down(tail_reg, cap_reg);
                    end
                end
            end
            MODE_PEEK_FRONT, MODE_PEEK_REAR:
            begin
                if (!empty_reg)
                begin
                    step.ok    = 1'b1;
                    step.rd_en = 1'b1;
                    step.addr  = (mode == MODE_PEEK_FRONT) ? head_reg : tail_reg;
                end
            end
            default:
            begin
                step.ok = 1'b0;
            end
        endcase
        step.now_empty = empty_next;
        step.now_full  = !empty_next && (wrap_up(tail_next, cap_reg) == head_next);
    end

    // index state; a capacity write empties the deque
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            empty_reg <= 1'b1;
            cap_reg   <= CAP_W'(CAP_RESET);
        end
        else if (cfg_wr)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            empty_reg <= 1'b1;
            cap_reg   <= cap_next;
        end
        else if (fire)
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            empty_reg <= empty_next;
        end
    end

endmodule

`default_nettype wire
